@@ rtl/tuvc_pkg.sv @@
package tuvc_pkg;

	localparam int unsigned DIV_A_CELLS = 64;
	localparam int unsigned DIV_B_CELLS = 32;

	localparam logic [31:0] NS_PER_SEC  = 32'd1000000000;
	localparam logic [31:0] NS_HALF_SEC = 32'd500000000;
	localparam logic [31:0] US_PER_SEC  = 32'd1000000;
	localparam logic [31:0] US_HALF_SEC = 32'd500000;
	localparam logic [31:0] FREQ_RESET  = 32'd62500000;

	typedef enum logic [1:0] {
		OP_NS_TO_TICKS = 2'd0,
		OP_US_TO_TICKS = 2'd1,
		OP_TICKS_TO_NS = 2'd2,
		OP_TICKS_TO_US = 2'd3
	} op_t;

	typedef struct packed {
		logic        valid;
		op_t         op;
		logic [31:0] divisor;
		logic [31:0] rem;
		logic [63:0] num;
		logic [63:0] quo;
		logic [31:0] mul;
		logic [31:0] half;
		logic [63:0] aux;
	} cell_t;

endpackage

@@ rtl/tuvc_if.sv @@
interface tuvc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [63:0] time_value;
	modport source (output valid, operation, time_value, input ready);
	modport sink (input valid, operation, time_value, output ready);
endinterface

interface tuvc_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] converted_value;
	modport source (output valid, converted_value, input ready);
	modport sink (input valid, converted_value, output ready);
endinterface

interface tuvc_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ rtl/tuvc_cell.sv @@
module tuvc_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  tuvc_pkg::cell_t cell_in,
	output tuvc_pkg::cell_t cell_out
);
	import tuvc_pkg::*;

	logic [32:0] trial;
	logic        ge;
	cell_t       nxt;
	cell_t       data_q;
	logic        valid_q;

	always_comb begin
		trial = {cell_in.rem, cell_in.num[63]};
		ge    = trial >= {1'b0, cell_in.divisor};
		nxt   = cell_in;
		nxt.rem = ge ? 32'(trial - {1'b0, cell_in.divisor}) : trial[31:0];
		nxt.quo = {cell_in.quo[62:0], ge};
		nxt.num = {cell_in.num[62:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	always_comb begin
		cell_out       = data_q;
		cell_out.valid = valid_q;
	end
endmodule

@@ rtl/tuvc_chain.sv @@
module tuvc_chain #(
	parameter int unsigned NUM_CELLS = tuvc_pkg::DIV_A_CELLS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  tuvc_pkg::cell_t chain_in,
	output tuvc_pkg::cell_t chain_out
);
	import tuvc_pkg::*;

	cell_t link [NUM_CELLS+1];

	assign link[0] = chain_in;

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		tuvc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.cell_in (link[g]),
			.cell_out(link[g+1])
		);
	end

	assign chain_out = link[NUM_CELLS];
endmodule

@@ rtl/timebase_unit_converter.sv @@
// Converts 64-bit time values between counter ticks and ns or us. One item is
// accepted per clock unless a stall holds the input; on its way to the result,
// 64 one-bit divider cells split the value into whole seconds and remainder,
// two multiply and add stages follow, then 32 more divider cells scale the
// remainder, and an output register holds the result. A result that is not
// taken stalls the whole pipeline, input included. Conversions into ticks
// round the remainder to the nearest tick, conversions out of ticks truncate,
// and ticks to ns or us give 0 while the frequency is 0. The frequency
// register resets to 62.5 MHz and may be written at any time; each item uses
// the frequency held when it was accepted.
module timebase_unit_converter (
	input logic        clk,
	input logic        arst_n,
	tuvc_cfg_if.sink   cfg,
	tuvc_req_if.sink   request,
	tuvc_rsp_if.source response
);
	import tuvc_pkg::*;

	logic [31:0] freq_q;
	logic        en;
	cell_t       a_in, a_out, b_in, b_out;
	logic [31:0] mul_val, half_val, div_val;

	logic        valid_s1, valid_s2;
	op_t         op_s1, op_s2;
	logic [31:0] div_s1, div_s2, half_s1;
	logic [63:0] plo_s1, pm_s1, wm_s2, dvd_s2;
	logic [31:0] phi_s1;

	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic [63:0] result;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FREQ_RESET;
		end else if (cfg.valid) begin
			freq_q <= cfg.data;
		end
	end

	assign en = !out_valid_q || response.ready;
	assign request.ready = en;

	always_comb begin
		unique case (op_t'(request.operation))
			OP_NS_TO_TICKS: begin
				half_val = NS_HALF_SEC;
				div_val  = NS_PER_SEC;
				mul_val  = freq_q;
			end
			OP_US_TO_TICKS: begin
				half_val = US_HALF_SEC;
				div_val  = US_PER_SEC;
				mul_val  = freq_q;
			end
			OP_TICKS_TO_NS: begin
				half_val = '0;
				div_val  = freq_q;
				mul_val  = NS_PER_SEC;
			end
			default: begin
				half_val = '0;
				div_val  = freq_q;
				mul_val  = US_PER_SEC;
			end
		endcase
		a_in.valid   = request.valid;
		a_in.op      = op_t'(request.operation);
		a_in.divisor = div_val;
		a_in.rem     = '0;
		a_in.num     = request.time_value;
		a_in.quo     = '0;
		a_in.mul     = mul_val;
		a_in.half    = half_val;
		a_in.aux     = '0;
	end

	// whole seconds and remainder
	tuvc_chain #(.NUM_CELLS(DIV_A_CELLS)) u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.chain_in (a_in),
		.chain_out(a_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= a_out.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= a_out.op;
			div_s1  <= a_out.divisor;
			half_s1 <= a_out.half;
			plo_s1  <= a_out.quo[31:0] * a_out.mul;
			phi_s1  <= 32'(a_out.quo[63:32] * a_out.mul);
			pm_s1   <= a_out.rem * a_out.mul;
			op_s2   <= op_s1;
			div_s2  <= div_s1;
			wm_s2   <= plo_s1 + {phi_s1, 32'h0};
			dvd_s2  <= pm_s1 + {32'h0, half_s1};
		end
	end

	always_comb begin
		b_in.valid   = valid_s2;
		b_in.op      = op_s2;
		b_in.divisor = div_s2;
		b_in.rem     = dvd_s2[63:32];
		b_in.num     = {dvd_s2[31:0], 32'h0};
		b_in.quo     = '0;
		b_in.mul     = '0;
		b_in.half    = '0;
		b_in.aux     = wm_s2;
	end

	// scaled remainder
	tuvc_chain #(.NUM_CELLS(DIV_B_CELLS)) u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.chain_in (b_in),
		.chain_out(b_out)
	);

	assign result = ((b_out.op == OP_TICKS_TO_NS || b_out.op == OP_TICKS_TO_US)
		&& b_out.divisor == '0) ? '0 : b_out.aux + b_out.quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= b_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= result;
		end
	end

	assign response.valid           = out_valid_q;
	assign response.converted_value = out_data_q;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> request.ready)
		else $error("request stalled with empty output register");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(a_out.valid && a_out.divisor != '0) |-> (a_out.rem < a_out.divisor))
		else $error("remainder not below divisor");

	a_quotient_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && div_s2 != '0) |-> (dvd_s2[63:32] < div_s2))
		else $error("scaled remainder quotient exceeds 32 bits");
endmodule
